// ===== src/mctt_pkg.sv =====
// shared types and constants for the multi-channel timeout timer
package mctt_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CHAN_W  = 3;
  localparam int unsigned DELAY_W = 32;
  localparam int unsigned COUNT_W = 26;
  localparam int unsigned MASK_W  = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // command codes; the fourth code is unused and falls to a default arm
  typedef enum logic [CMD_W-1:0] {
    CMD_SET    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_t;

  // one decoded operation handed to the counter bank
  typedef struct packed {
    logic               fire;
    cmd_t               cmd;
    logic [CHAN_W-1:0]  channel;
    logic [COUNT_W-1:0] ticks;
  } op_t;

  // what the bank reports for one operation
  typedef struct packed {
    logic [MASK_W-1:0] expired_mask;
    logic              running;
  } res_t;

endpackage

// ===== src/mctt_div.sv =====
// delay to tick count conversion by reciprocal multiply, saturating
module mctt_div #(
  parameter int unsigned TICK_PERIOD_US = 100
) (
  input  logic [mctt_pkg::DELAY_W-1:0] delay,
  output logic [mctt_pkg::COUNT_W-1:0] ticks
);
  import mctt_pkg::*;

  // exact floor division of a 32-bit value: m = ceil(2^(32+l) / d), l = ceil(log2 d)
  localparam int unsigned SHIFT_L = $clog2(TICK_PERIOD_US);
  localparam int unsigned SHIFT   = DELAY_W + SHIFT_L;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(TICK_PERIOD_US) - 64'd1) / 64'(TICK_PERIOD_US);
  localparam logic [DELAY_W:0] RECIP = RECIP_FULL[DELAY_W:0];
  localparam int unsigned PROD_W = 2 * DELAY_W + 1;

  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  prod_sh;
  logic [DELAY_W-1:0] quot;

  assign prod    = {{(DELAY_W+1){1'b0}}, delay} * {{DELAY_W{1'b0}}, RECIP};
  assign prod_sh = prod >> SHIFT;
  assign quot    = prod_sh[DELAY_W-1:0];

  always_comb begin
    if (quot > {{(DELAY_W-COUNT_W){1'b0}}, COUNT_MAX}) begin
      ticks = COUNT_MAX;
    end else begin
      ticks = quot[COUNT_W-1:0];
    end
  end

endmodule

// ===== src/mctt_bank.sv =====
// bank of countdown registers with the running flag and expiry mask logic
module mctt_bank #(
  parameter int unsigned CHANNELS = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mctt_pkg::op_t   op,
  output mctt_pkg::res_t  res
);
  import mctt_pkg::*;

  logic [COUNT_W-1:0] cnt_r   [CHANNELS];
  logic [COUNT_W-1:0] cnt_nxt [CHANNELS];
  logic               active_r;
  logic               active_nxt;
  logic [CHANNELS-1:0] expire;
  logic [CHANNELS-1:0] left;
  logic [CHANNELS-1:0] busy;
  logic               in_range;
  logic               tick_go;

  assign in_range = 32'(op.channel) < CHANNELS;
  assign tick_go  = op.fire && (op.cmd == CMD_TICK) && active_r;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    logic hit;
    assign hit     = op.fire && (32'(op.channel) == c);
    assign busy[c] = cnt_r[c] != '0;
    assign expire[c] = tick_go && (cnt_r[c] == COUNT_W'(1));
    assign left[c]   = tick_go && busy[c] && (cnt_r[c] != COUNT_W'(1));

    always_comb begin
      cnt_nxt[c] = cnt_r[c];
      unique case (op.cmd)
        CMD_SET: begin
          if (hit) cnt_nxt[c] = op.ticks;
        end
        CMD_CANCEL: begin
          if (hit) cnt_nxt[c] = '0;
        end
        CMD_TICK: begin
          if (tick_go && busy[c]) cnt_nxt[c] = cnt_r[c] - COUNT_W'(1);
        end
        default: begin
          cnt_nxt[c] = cnt_r[c];
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r[c] <= '0;
      end else begin
        cnt_r[c] <= cnt_nxt[c];
      end
    end
  end

  always_comb begin
    active_nxt = active_r;
    if (op.fire && (op.cmd == CMD_SET) && in_range) begin
      active_nxt = 1'b1;
    end else if (tick_go && (left == '0)) begin
      active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  // channels beyond the mask width count but are not reported
  for (genvar i = 0; i < MASK_W; i++) begin : g_mask
    if (i < CHANNELS) begin : g_on
      assign res.expired_mask[i] = expire[i];
    end else begin : g_off
      assign res.expired_mask[i] = 1'b0;
    end
  end

  assign res.running = active_nxt;

  a_set_starts: assert property (@(posedge clk) disable iff (!rst_n)
    op.fire && (op.cmd == CMD_SET) && in_range |=> active_r)
    else $error("bank not running after an in-range set");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (busy == '0))
    else $error("count left nonzero while the bank is stopped");

  a_mask_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (res.expired_mask != '0) |-> tick_go)
    else $error("expiry reported outside a processed tick");

  a_stop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    tick_go && (left == '0) |=> !active_r && (busy == '0))
    else $error("bank kept running after last count expired");

endmodule

// ===== src/multi_channel_timeout_timer_unit.sv =====
// top level of the multi-channel timeout timer
//
//   channel  ports                                      direction
//   in       in_valid/in_ready, command/channel/delay   request into the bank
//   out      out_valid/out_ready, expired_mask/running  one result per request
//
// one transfer per cycle on each side when nothing stalls
// an accepted request passes from the input register to the result register, which raises out_valid
// reset (rst_n low, synchronous) clears every count, the running flag and the valid flags of both stages
// a stalled result holds the output register; the input register then fills
// and in_ready drops until the result is taken
module multi_channel_timeout_timer_unit #(
  parameter int unsigned CHANNELS       = 6,
  parameter int unsigned TICK_PERIOD_US = 100
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mctt_pkg::CMD_W-1:0]    in_command,
  input  logic [mctt_pkg::CHAN_W-1:0]   in_channel,
  input  logic [mctt_pkg::DELAY_W-1:0]  in_delay,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mctt_pkg::MASK_W-1:0]   out_expired_mask,
  output logic                          out_running
);
  import mctt_pkg::*;

  // input register stage
  logic               q_valid_r;
  logic [CMD_W-1:0]   q_command_r;
  logic [CHAN_W-1:0]  q_channel_r;
  logic [DELAY_W-1:0] q_delay_r;

  // result register stage
  logic              out_valid_r;
  logic [MASK_W-1:0] out_mask_r;
  logic              out_running_r;

  logic               adv;
  logic               in_xfer;
  logic [COUNT_W-1:0] ticks;
  op_t                op;
  res_t               res;

  // the held item moves on whenever the result register is free or being emptied
  assign adv      = q_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !q_valid_r || adv;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else if (in_ready) begin
      q_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      q_command_r <= in_command;
      q_channel_r <= in_channel;
      q_delay_r   <= in_delay;
    end
  end

  // microseconds to ticks, truncating and saturating to the count width
  mctt_div #(
    .TICK_PERIOD_US (TICK_PERIOD_US)
  ) u_div (
    .delay (q_delay_r),
    .ticks (ticks)
  );

  assign op.fire    = adv;
  assign op.cmd     = cmd_t'(q_command_r);
  assign op.channel = q_channel_r;
  assign op.ticks   = ticks;

  // counters and running flag update on the same edge that loads the result
  mctt_bank #(
    .CHANNELS (CHANNELS)
  ) u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_mask_r    <= res.expired_mask;
      out_running_r <= res.running;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_expired_mask = out_mask_r;
  assign out_running      = out_running_r;

endmodule
